### sv/cartesian_to_polar_turns_defines.svh
// assertion helpers for the cartesian to polar block
`ifndef CARTESIAN_TO_POLAR_TURNS_DEFINES_SVH
`define CARTESIAN_TO_POLAR_TURNS_DEFINES_SVH

// same-cycle implication, off while reset is low
`define CTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ctp assertion failed");

// next-cycle implication, off while reset is low
`define CTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ctp assertion failed");

`endif

### sv/ctp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

    // normalized vector magnitude has exactly this many bits
    localparam int NORM_BITS  = 30;
    // signed width of the rotation datapath, holds the cordic gain growth
    localparam int WORK_BITS  = NORM_BITS + 4;
    // width of the normalization shift count
    localparam int SHIFT_BITS = 5;
    // width of the radius rounding shift count
    localparam int SH_BITS    = 7;
    localparam int ACC_BITS   = 32;
    localparam int TABLE_LEN  = 24;

    // 1/K in Q32
    localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;

    // atan(2^-i) in units of 2^-32 turn
    localparam logic [ACC_BITS-1:0] ARC_TABLE [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // word state carried through the rotation stages
    typedef struct packed {
        logic                        zero;
        logic [SHIFT_BITS-1:0]       shift;
        logic signed [WORK_BITS-1:0] u;
        logic signed [WORK_BITS-1:0] v;
        logic [ACC_BITS-1:0]         acc;
    } t_rot;

endpackage

`default_nettype wire

### sv/ctp_intf.sv
`timescale 1ns / 1ps
`default_nettype none

// input coordinate channel
interface ctp_in_if #(
    parameter int COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;

    modport source (output valid, output pos_x, output pos_y, input ready);
    modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

// polar result channel
interface ctp_out_if #(
    parameter int RADIUS_BITS = 17,
    parameter int ANGLE_BITS  = 16
);
    logic                   valid;
    logic                   ready;
    logic [RADIUS_BITS-1:0] radius;
    logic [ANGLE_BITS-1:0]  turn_angle;

    modport source (output valid, output radius, output turn_angle, input ready);
    modport sink   (input valid, input radius, input turn_angle, output ready);
endinterface

// configuration write channel
interface ctp_cfg_if #(
    parameter int DATA_BITS = 12
);
    logic                               valid;
    logic                               ready;
    logic [ctp_pkg::CFG_IDX_BITS-1:0]   index;
    logic [DATA_BITS-1:0]               data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### sv/ctp_cordic_stage.sv
`timescale 1ns / 1ps
`default_nettype none

// one vectoring micro-rotation, registered
module ctp_cordic_stage #(
    parameter int STEP = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire ctp_pkg::t_rot i_rot,
    output logic               o_vld,
    output ctp_pkg::t_rot      o_rot
);

    logic                                 r_vld;
    ctp_pkg::t_rot                        r_rot;
    ctp_pkg::t_rot                        n_rot;
    logic signed [ctp_pkg::WORK_BITS-1:0] du;
    logic signed [ctp_pkg::WORK_BITS-1:0] dv;

    always_comb begin
        n_rot = i_rot;
        du    = i_rot.v >>> STEP;
        dv    = i_rot.u >>> STEP;
        if (i_rot.v > 0) begin
            n_rot.u   = i_rot.u + du;
            n_rot.v   = i_rot.v - dv;
            n_rot.acc = i_rot.acc + ctp_pkg::ARC_TABLE[STEP];
        end else begin
            n_rot.u   = i_rot.u - du;
            n_rot.v   = i_rot.v + dv;
            n_rot.acc = i_rot.acc - ctp_pkg::ARC_TABLE[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rot <= n_rot;
        end
    end

    assign o_vld = r_vld;
    assign o_rot = r_rot;

endmodule

`default_nettype wire

### sv/cartesian_to_polar_turns.sv
// cartesian to polar conversion, angle in turns clockwise from up
// channels: i_in carries pos_x / pos_y words, o_out returns radius / turn_angle
// words, one result word per input word and in order. i_cfg writes center_x
// (index 0) and center_y (index 1); other indexes are dropped. i_cfg is
// always ready; write it only while no word is in flight.
// throughput: one word per cycle, no bubbles while o_out is taken.
// from input accept to output a word passes the capture, normalize,
// one stage per micro-rotation, multiply and round registers.
// the depth is set by the rotation stages, each an add/sub on u, v and angle.
// stall: the whole pipeline holds when o_out is valid and not ready; i_in
// ready drops in that cycle, nothing is lost or repeated.
// reset: all stage valid bits clear, both center registers go to 0.
// radius has RADIUS_FRAC_BITS fraction bits, turn_angle wraps at one turn,
// the center point gives radius 0 and angle 0.
`timescale 1ns / 1ps
`default_nettype none
`include "cartesian_to_polar_turns_defines.svh"

module cartesian_to_polar_turns #(
    parameter int COORD_BITS       = 12,
    parameter int ANGLE_BITS       = 16,
    parameter int RADIUS_FRAC_BITS = 4,
    parameter int ROTATION_STEPS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ctp_in_if.sink     i_in,
    ctp_out_if.source  o_out,
    ctp_cfg_if.sink    i_cfg
);

    localparam int RADIUS_W = COORD_BITS + 1 + RADIUS_FRAC_BITS;
    // signed width of dx, dy and their negations
    localparam int DW       = COORD_BITS + 2;
    localparam int WB       = ctp_pkg::WORK_BITS;
    localparam int SB       = ctp_pkg::SHIFT_BITS;
    localparam int HB       = ctp_pkg::SH_BITS;
    localparam int AB       = ctp_pkg::ACC_BITS;

    // global advance: the output register is free or being taken
    logic en;

    // configuration
    logic [COORD_BITS-1:0] r_center_x;
    logic [COORD_BITS-1:0] r_center_y;

    // stage a: offsets, folded into the upper half plane
    logic                 r_a_vld;
    logic signed [DW-1:0] r_a_u;
    logic signed [DW-1:0] r_a_v;
    logic                 r_a_flip;
    logic                 r_a_zero;
    logic signed [DW-1:0] n_a_u;
    logic signed [DW-1:0] n_a_v;
    logic                 n_a_flip;
    logic                 n_a_zero;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;

    // stage b: normalized vector
    logic                 r_b_vld;
    ctp_pkg::t_rot        r_b_rot;
    ctp_pkg::t_rot        n_b_rot;
    logic [DW-1:0]        mag_v;
    logic [DW-1:0]        mag_m;
    logic [SB-1:0]        bit_len;

    // rotation chain
    logic                 w_vld [ROTATION_STEPS+1];
    ctp_pkg::t_rot        w_rot [ROTATION_STEPS+1];

    // stage m: gain removal product
    logic                 r_m_vld;
    logic [63:0]          r_m_prod;
    logic [SB-1:0]        r_m_shift;
    logic [AB-1:0]        r_m_acc;
    logic                 r_m_zero;
    logic [31:0]          u_clamp;

    // stage o: output register
    logic                 r_o_vld;
    logic [RADIUS_W-1:0]  r_o_radius;
    logic [ANGLE_BITS-1:0] r_o_angle;
    logic [HB-1:0]        rad_sh;
    logic [63:0]          rad_round;
    logic [AB:0]          ang_round;
    logic [RADIUS_W-1:0]  n_o_radius;
    logic [ANGLE_BITS-1:0] n_o_angle;

    assign en = !r_o_vld || o_out.ready;

    // configuration port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ctp_pkg::CFG_CENTER_X: r_center_x <= i_cfg.data;
                ctp_pkg::CFG_CENTER_Y: r_center_y <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage a: dx right, u up; rotate by a half turn when pointing down
    assign i_in.ready = en;

    always_comb begin
        dx       = DW'(i_in.pos_x) - DW'(r_center_x);
        dy       = DW'(i_in.pos_y) - DW'(r_center_y);
        n_a_zero = (dx == '0) && (dy == '0);
        n_a_u    = -dy;
        n_a_v    = dx;
        n_a_flip = 1'b0;
        if (dy > 0) begin
            n_a_u    = dy;
            n_a_v    = -dx;
            n_a_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_u    <= n_a_u;
            r_a_v    <= n_a_v;
            r_a_flip <= n_a_flip;
            r_a_zero <= n_a_zero;
        end
    end

    // stage b: shift so the larger component has exactly NORM_BITS bits
    always_comb begin
        mag_v   = r_a_v[DW-1] ? DW'(-r_a_v) : DW'(r_a_v);
        mag_m   = (DW'(r_a_u) > mag_v) ? DW'(r_a_u) : mag_v;
        bit_len = '0;
        for (int b = 0; b < DW; b++) begin
            if (mag_m[b]) begin
                bit_len = SB'(b + 1);
            end
        end
        n_b_rot.zero  = r_a_zero;
        n_b_rot.shift = SB'(ctp_pkg::NORM_BITS) - bit_len;
        n_b_rot.u     = WB'(r_a_u) <<< n_b_rot.shift;
        n_b_rot.v     = WB'(r_a_v) <<< n_b_rot.shift;
        n_b_rot.acc   = {r_a_flip, {(AB-1){1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_rot <= n_b_rot;
        end
    end

    // micro-rotations, one per stage
    assign w_vld[0] = r_b_vld;
    assign w_rot[0] = r_b_rot;

    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_rot
        ctp_cordic_stage #(
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_vld   (w_vld[g]),
            .i_rot   (w_rot[g]),
            .o_vld   (w_vld[g+1]),
            .o_rot   (w_rot[g+1])
        );
    end

    // stage m: clamp and scale by 1/K
    assign u_clamp = w_rot[ROTATION_STEPS].u[WB-1] ? 32'd0 : w_rot[ROTATION_STEPS].u[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (en) begin
            r_m_vld <= w_vld[ROTATION_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_prod  <= 64'(u_clamp) * 64'(ctp_pkg::INV_GAIN_Q32);
            r_m_shift <= w_rot[ROTATION_STEPS].shift;
            r_m_acc   <= w_rot[ROTATION_STEPS].acc;
            r_m_zero  <= w_rot[ROTATION_STEPS].zero;
        end
    end

    // stage o: undo normalization with rounding, round the angle
    always_comb begin
        rad_sh     = HB'(32) + HB'(r_m_shift) - HB'(RADIUS_FRAC_BITS);
        rad_round  = (r_m_prod + (64'd1 << (rad_sh - HB'(1)))) >> rad_sh;
        ang_round  = {1'b0, r_m_acc} + ((AB+1)'(1) << (31 - ANGLE_BITS));
        n_o_radius = r_m_zero ? '0 : rad_round[RADIUS_W-1:0];
        n_o_angle  = r_m_zero ? '0 : ang_round[AB-ANGLE_BITS +: ANGLE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (en) begin
            r_o_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_radius <= n_o_radius;
            r_o_angle  <= n_o_angle;
        end
    end

    assign o_out.valid      = r_o_vld;
    assign o_out.radius     = r_o_radius;
    assign o_out.turn_angle = r_o_angle;

    // folding leaves the up component nonnegative after normalization
    `CTP_ASSERT_IMP(a_norm_up, i_clk, i_rst_n, r_b_vld, !r_b_rot.u[WB-1])
    // a held word blocks the input side
    `CTP_ASSERT_IMP(a_stall_blocks, i_clk, i_rst_n, r_o_vld && !o_out.ready, !i_in.ready)
    // center point comes out as zero radius and zero angle
    `CTP_ASSERT_NXT(a_center_zero, i_clk, i_rst_n, en && r_m_vld && r_m_zero,
        (r_o_radius == '0) && (r_o_angle == '0))

endmodule

`default_nettype wire

### bench/ctp_polar_checker.sv
`timescale 1ns / 1ps

// watches the coordinate, result and config channels, predicts each polar word
module ctp_polar_checker #(
    parameter int COORD_BITS       = 12,
    parameter int ANGLE_BITS       = 16,
    parameter int RADIUS_FRAC_BITS = 4,
    parameter int ROTATION_STEPS   = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [COORD_BITS-1:0]            i_pos_x,
    input  logic [COORD_BITS-1:0]            i_pos_y,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [COORD_BITS+RADIUS_FRAC_BITS:0] i_radius,
    input  logic [ANGLE_BITS-1:0]            i_turn_angle,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [ctp_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [COORD_BITS-1:0]            i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_checked
);

    localparam int RADIUS_BITS   = COORD_BITS + 1 + RADIUS_FRAC_BITS;
    localparam int UNIT_BITS     = 30;
    localparam int ARC_LEN       = 24;
    localparam logic [63:0] GAIN_RECIP = 64'd2608131496;

    // atan(2^-i) in 2^-32 turn
    localparam logic [31:0] ARCTAN_TURNS [ARC_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic [ANGLE_BITS-1:0]  turn_angle;
    } polar_word_t;

    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    polar_word_t           polar_expected_q [$];

    function automatic polar_word_t polar_of(input logic [COORD_BITS-1:0] px,
                                             input logic [COORD_BITS-1:0] py,
                                             input logic [COORD_BITS-1:0] cx,
                                             input logic [COORD_BITS-1:0] cy);
        longint      lpx, lpy, lcx, lcy;
        longint      up, right, step_u, step_v, mag;
        logic [31:0] turns;
        logic [63:0] len, prod, rad, ang;
        int          nbits, norm_sh, rnd_sh;
        polar_word_t res;
        lpx = px;
        lpy = py;
        lcx = cx;
        lcy = cy;
        up    = lcy - lpy;
        right = lpx - lcx;
        turns = '0;
        res   = '0;
        if (up == 0 && right == 0)
            return res;
        // lower half plane: rotate by half a turn first
        if (up < 0) begin
            up    = -up;
            right = -right;
            turns = 32'h80000000;
        end
        mag   = (right < 0) ? -right : right;
        if (up > mag)
            mag = up;
        nbits = 0;
        while (mag != 0) begin
            nbits++;
            mag = mag >> 1;
        end
        // scale the vector to a fixed working magnitude
        norm_sh = UNIT_BITS - nbits;
        up      = up * (longint'(1) << norm_sh);
        right   = right * (longint'(1) << norm_sh);
        for (int i = 0; i < ROTATION_STEPS && i < ARC_LEN; i++) begin
            step_u = right >>> i;
            step_v = up >>> i;
            if (right > 0) begin
                up    = up + step_u;
                right = right - step_v;
                turns = turns + ARCTAN_TURNS[i];
            end else begin
                up    = up - step_u;
                right = right + step_v;
                turns = turns - ARCTAN_TURNS[i];
            end
        end
        if (up < 0)
            up = 0;
        len    = up;
        prod   = len * GAIN_RECIP;
        rnd_sh = 32 + norm_sh - RADIUS_FRAC_BITS;
        rad    = (prod + (64'd1 << (rnd_sh - 1))) >> rnd_sh;
        ang    = ({32'd0, turns} + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
        res.radius     = rad[RADIUS_BITS-1:0];
        res.turn_angle = ang[ANGLE_BITS-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        polar_word_t want;
        if (!i_rst_n) begin
            center_x = '0;
            center_y = '0;
            polar_expected_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_checked    <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (polar_expected_q.size() == 0) begin
                    $error("polar word with no coordinate waiting: radius %0d angle %0d",
                           i_radius, i_turn_angle);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = polar_expected_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_radius !== want.radius || i_turn_angle !== want.turn_angle)
                        o_fail_count <= o_fail_count + 1;
                    if (i_radius !== want.radius)
                        $error("radius: expected %0d, got %0d", want.radius, i_radius);
                    if (i_turn_angle !== want.turn_angle)
                        $error("turn_angle: expected %0d, got %0d",
                               want.turn_angle, i_turn_angle);
                end
            end
            // a coordinate taken on the same edge as a write still sees the old center
            if (i_in_valid && i_in_ready)
                polar_expected_q.push_back(polar_of(i_pos_x, i_pos_y, center_x, center_y));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == ctp_pkg::CFG_CENTER_X)
                    center_x = i_cfg_data;
                else if (i_cfg_index == ctp_pkg::CFG_CENTER_Y)
                    center_y = i_cfg_data;
            end
            o_pending <= polar_expected_q.size();
        end
    end

endmodule

### bench/tb_cartesian_to_polar_turns.sv
`timescale 1ns / 1ps

// top of the bench: clock, reset, stimulus and the verdict
module tb_cartesian_to_polar_turns;

    localparam int COORD_BITS       = 12;
    localparam int ANGLE_BITS       = 16;
    localparam int RADIUS_FRAC_BITS = 4;
    localparam int ROTATION_STEPS   = 16;
    localparam int RADIUS_BITS      = COORD_BITS + 1 + RADIUS_FRAC_BITS;
    localparam int COORD_MAX        = (1 << COORD_BITS) - 1;
    localparam int COORD_MID        = 1 << (COORD_BITS - 1);
    // input accept to output accept through the block's register stages
    localparam int PIPE_LATENCY     = ROTATION_STEPS + 4;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int WORDS_PER_PHASE  = 120;
    localparam int RANDOM_PHASES    = 5;

    // indexes past center_y, the block must drop these writes
    localparam logic [ctp_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [ctp_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

    logic i_clk;
    logic i_rst_n;

    ctp_in_if  #(.COORD_BITS(COORD_BITS))                        in_ch ();
    ctp_out_if #(.RADIUS_BITS(RADIUS_BITS), .ANGLE_BITS(ANGLE_BITS)) out_ch ();
    ctp_cfg_if #(.DATA_BITS(COORD_BITS))                         cfg_ch ();

    int fail_count;
    int pending_words;
    int checked_words;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;
    int center_settings;
    int cur_cx;
    int cur_cy;

    cartesian_to_polar_turns #(
        .COORD_BITS       (COORD_BITS),
        .ANGLE_BITS       (ANGLE_BITS),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS),
        .ROTATION_STEPS   (ROTATION_STEPS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // predicts every polar word and compares it on the way out
    ctp_polar_checker #(
        .COORD_BITS       (COORD_BITS),
        .ANGLE_BITS       (ANGLE_BITS),
        .RADIUS_FRAC_BITS (RADIUS_FRAC_BITS),
        .ROTATION_STEPS   (ROTATION_STEPS)
    ) u_polar_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_pos_x      (in_ch.pos_x),
        .i_pos_y      (in_ch.pos_y),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_radius     (out_ch.radius),
        .i_turn_angle (out_ch.turn_angle),
        .i_cfg_valid  (cfg_ch.valid),
        .i_cfg_ready  (cfg_ch.ready),
        .i_cfg_index  (cfg_ch.index),
        .i_cfg_data   (cfg_ch.data),
        .o_fail_count (fail_count),
        .o_pending    (pending_words),
        .o_checked    (checked_words)
    );

    // 10 ns clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, generous against the slowest legal run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("cartesian_to_polar_turns: mismatch");
                $finish;
            end
        end
    end

    // result side: ready drops at random per the current stall mix
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // clamp a signed offset back onto the pixel grid
    function automatic logic [COORD_BITS-1:0] clip_coord(input int c);
        if (c < 0)
            return '0;
        if (c > COORD_MAX)
            return COORD_MAX[COORD_BITS-1:0];
        return c[COORD_BITS-1:0];
    endfunction

    // one coordinate word, called at a falling edge, returns at a falling edge;
    // valid stays high into the next call unless that call idles first
    task automatic send_coord(input logic [COORD_BITS-1:0] x,
                              input logic [COORD_BITS-1:0] y);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.pos_x <= x;
        in_ch.pos_y <= y;
        do
            @(posedge i_clk);
        while (!in_ch.ready);
        words_sent++;
        @(negedge i_clk);
    endtask

    // stop sending and wait for every polar word still in flight
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending_words != 0)
            @(negedge i_clk);
    endtask

    // config write, only with the pipe empty
    task automatic write_reg(input logic [ctp_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [COORD_BITS-1:0] data);
        drain_pipe();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_center(input int cx, input int cy);
        write_reg(ctp_pkg::CFG_CENTER_X, cx[COORD_BITS-1:0]);
        write_reg(ctp_pkg::CFG_CENTER_Y, cy[COORD_BITS-1:0]);
        cur_cx = cx;
        cur_cy = cy;
        center_settings++;
    endtask

    initial begin
        int pick;
        int d;
        logic [COORD_BITS-1:0] rx;
        logic [COORD_BITS-1:0] ry;

        // every input known from time zero
        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.pos_x     = '0;
        in_ch.pos_y     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = ctp_pkg::CFG_CENTER_X;
        cfg_ch.data     = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        words_sent      = 0;
        center_settings = 1;
        cur_cx          = 0;
        cur_cy          = 0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset center sits in the top-left corner
        send_coord(0, 0);                  // point on the center
        send_coord(COORD_MAX, COORD_MAX);  // farthest point, down-right
        send_coord(COORD_MAX, 0);          // straight right, quarter turn
        send_coord(0, COORD_MAX);          // straight down, half turn

        // directed: center mid-screen, the four axes and their neighbors
        set_center(COORD_MID, COORD_MID);
        send_coord(COORD_MID, 0);              // straight up, angle 0
        send_coord(COORD_MAX, COORD_MID);      // right
        send_coord(COORD_MID, COORD_MAX);      // down
        send_coord(0, COORD_MID);              // left, three quarters
        send_coord(COORD_MID, COORD_MID);      // on the center again
        send_coord(COORD_MID - 1, 0);          // just left of up, close to a full turn
        send_coord(COORD_MID + 1, 0);          // just right of up
        send_coord(COORD_MID, COORD_MID - 1);  // one pixel up, smallest magnitude
        send_coord(COORD_MID + 1, COORD_MID);  // one pixel right
        send_coord(COORD_MID - 1, COORD_MID + 1);
        send_coord(0, 0);
        send_coord(COORD_MAX, COORD_MAX);

        // writes past center_y must leave the center alone
        write_reg(CFG_SPARE_LO, 12'h005);
        write_reg(CFG_SPARE_HI, COORD_MAX[COORD_BITS-1:0]);
        send_coord(COORD_MID, 0);
        send_coord(COORD_MAX, 0);
        send_coord(0, COORD_MAX);

        // directed: center at the far corner, points up-left, straight up and on the center
        set_center(COORD_MAX, COORD_MAX);
        send_coord(0, 0);
        send_coord(COORD_MAX, COORD_MAX);
        send_coord(COORD_MAX, 0);

        // random phases, each with its own center and one of four idle mixes
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_pipe();
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_center(0, COORD_MAX);
                end
                1: begin
                    send_idle_pct  = 79;
                    recv_stall_pct = 0;
                    set_center(COORD_MAX, 0);
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 79;
                    set_center($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                end
                3: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                    set_center(0, 0);
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    set_center($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
                end
            endcase
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                // halfway through, hold the sender until the pipe is empty
                if (n == WORDS_PER_PHASE / 2)
                    drain_pipe();
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    // anywhere on the grid
                    rx = $urandom_range(0, COORD_MAX);
                    ry = $urandom_range(0, COORD_MAX);
                end else if (pick < 70) begin
                    // close to the center, small vectors
                    rx = clip_coord(cur_cx + int'($urandom_range(0, 24)) - 12);
                    ry = clip_coord(cur_cy + int'($urandom_range(0, 24)) - 12);
                end else if (pick < 80) begin
                    // on a horizontal or vertical line through the center
                    if ($urandom_range(0, 1)) begin
                        rx = cur_cx[COORD_BITS-1:0];
                        ry = $urandom_range(0, COORD_MAX);
                    end else begin
                        rx = $urandom_range(0, COORD_MAX);
                        ry = cur_cy[COORD_BITS-1:0];
                    end
                end else if (pick < 90) begin
                    // on a diagonal, eighth-turn boundaries
                    d  = $urandom_range(1, COORD_MAX);
                    rx = clip_coord($urandom_range(0, 1) ? cur_cx + d : cur_cx - d);
                    ry = clip_coord($urandom_range(0, 1) ? cur_cy + d : cur_cy - d);
                end else begin
                    // grid corners
                    rx = $urandom_range(0, 1) ? COORD_MAX[COORD_BITS-1:0] : '0;
                    ry = $urandom_range(0, 1) ? COORD_MAX[COORD_BITS-1:0] : '0;
                end
                send_coord(rx, ry);
            end
        end

        drain_pipe();
        repeat (PIPE_LATENCY + 5) @(posedge i_clk);

        $display("covered %0d coordinate words under %0d center settings, spare register writes,",
                 words_sent, center_settings);
        $display("and four idle mixes; %0d polar words compared", checked_words);
        if (fail_count == 0)
            $display("cartesian_to_polar_turns: match");
        else
            $display("cartesian_to_polar_turns: mismatch");
        $finish;
    end

endmodule

### cartesian_to_polar_turns.f
+incdir+sv
sv/ctp_pkg.sv
sv/ctp_intf.sv
sv/ctp_cordic_stage.sv
sv/cartesian_to_polar_turns.sv
bench/ctp_polar_checker.sv
bench/tb_cartesian_to_polar_turns.sv
